// ===== sv/assert_macros.svh =====
// Assertion macros for the CPU step checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ===== sv/sbacs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbacs_pkg
// Shared types and constants of the CPU step block.
// ----------------------------------------------------------------------------
package sbacs_pkg;
    localparam int MEM_WORDS = 256;
    localparam int MEM_AW = $clog2(MEM_WORDS);

    localparam logic [2:0] MODE_WMEM = 3'd0;
    localparam logic [2:0] MODE_RMEM = 3'd1;
    localparam logic [2:0] MODE_WCTX = 3'd2;
    localparam logic [2:0] MODE_SLICE = 3'd3;
    localparam logic [2:0] MODE_EXEC = 3'd4;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_SIZE = 2'd1;
    localparam logic [1:0] CFG_SLICE = 2'd2;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_SLICE = 3'd1;
    localparam logic [2:0] EV_HALT = 3'd2;
    localparam logic [2:0] EV_OOB = 3'd3;
    localparam logic [2:0] EV_BADOP = 3'd4;
    localparam logic [2:0] EV_READ = 3'd5;
    localparam logic [2:0] EV_WRITE = 3'd6;

    localparam logic [4:0] OP_LOAD = 5'd0, OP_STORE = 5'd1, OP_ADD = 5'd2,
        OP_ADDC = 5'd3, OP_SUB = 5'd4, OP_SUBC = 5'd5, OP_AND = 5'd6, OP_XOR = 5'd7,
        OP_COMPL = 5'd8, OP_SHL = 5'd9, OP_SHLA = 5'd10, OP_SHR = 5'd11,
        OP_SHRA = 5'd12, OP_CMP = 5'd13, OP_GETS = 5'd14, OP_PUTS = 5'd15,
        OP_JMP = 5'd16, OP_JLT = 5'd17, OP_JEQ = 5'd18, OP_JGT = 5'd19,
        OP_CALL = 5'd20, OP_RET = 5'd21, OP_TRD = 5'd22, OP_TWR = 5'd23,
        OP_HALT = 5'd24, OP_NOOP = 5'd25;

    typedef enum logic [3:0] {
        S_IDLE, S_ACCESS, S_FETCH, S_DECODE, S_EXEC, S_MEMWAIT,
        S_PUSH, S_POP, S_POPWAIT, S_CHECK, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        C_NONE, C_DIRECT, C_PRECHECK, C_FETCH, C_DECODE, C_EXEC, C_LOADWB,
        C_PUSH, C_POPRD, C_POPWB, C_POSTCHECK
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
    } t_cmd;

    typedef struct packed {
        logic stop;      // a bound check or execute ended the step
        logic is_load;   // memory load waits for data
        logic is_call;
        logic is_ret;
        logic last;      // final stack word of call/return
    } t_status;
endpackage

// ===== sv/sbacs_datapath.sv =====
// ----------------------------------------------------------------------------
// sbacs_datapath
// Registers, memory, ALU and bound checks of the CPU step block.
// ----------------------------------------------------------------------------
module sbacs_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbacs_pkg::t_cmd      i_cmd,
    output sbacs_pkg::t_status   o_status,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [2:0]           i_mode,
    input  logic [7:0]           i_location,
    input  logic [15:0]          i_value,
    output logic [15:0]          o_read_word,
    output logic [15:0]          o_status_word,
    output logic [8:0]           o_program_counter,
    output logic [8:0]           o_stack_top,
    output logic [31:0]          o_elapsed_clock,
    output logic [2:0]           o_stop_event
);
    import sbacs_pkg::*;

    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_rdata;
    logic [15:0] r_regs [4];
    logic [15:0] r_sr;
    logic [8:0]  r_ip, r_sp;
    logic [31:0] r_clk, r_dl;
    logic        r_stopped;
    logic [7:0]  r_base;
    logic [8:0]  r_size;
    logic [15:0] r_slen;
    logic [15:0] r_ir;
    logic [2:0]  r_cnt;
    logic [15:0] r_rword;
    logic [2:0]  r_ev;
    logic        r_stop;
    logic [2:0]  r_mode;
    logic [7:0]  r_loc;
    logic [15:0] r_val;

    logic        mem_we;
    logic [MEM_AW-1:0] mem_wa, mem_ra;
    logic [15:0] mem_wd;

    logic [4:0]  op;
    logic [1:0]  rd, rs;
    logic        imm;
    logic [7:0]  addr;
    logic [15:0] k, src, dv;
    logic [8:0]  jt;
    logic [31:0] dd;
    logic        ip_oob, slice_over, addr_oob;
    logic [16:0] sum;
    logic [8:0]  sp_dec;
    logic        exec_oob, mem_cost, jmp_take, cmp_lt, cmp_eq;

    assign op   = r_ir[15:11];
    assign rd   = r_ir[10:9];
    assign imm  = r_ir[8];
    assign rs   = r_ir[7:6];
    assign addr = r_ir[7:0];
    assign k    = {{8{addr[7]}}, addr};
    assign src  = imm ? k : r_regs[rs];
    assign dv   = r_regs[rd];
    assign jt   = {1'b0, addr} + {1'b0, r_base};
    assign ip_oob = ({1'b0, r_ip} >= ({1'b0, r_base} + {1'b0, r_size}));
    assign dd   = r_dl - r_clk;
    assign slice_over = !(dd != 32'd0 && !dd[31]);
    assign addr_oob = ({1'b0, addr} >= r_size);
    assign sp_dec = r_sp - 9'd1;

    assign exec_oob = ((op == OP_LOAD && !imm) || op == OP_STORE || op == OP_JMP ||
                       op == OP_JLT || op == OP_JEQ || op == OP_JGT) && addr_oob;
    assign mem_cost = !exec_oob && ((op == OP_LOAD && !imm) || op == OP_STORE ||
                                    op == OP_CALL || op == OP_RET);
    assign jmp_take = !exec_oob && (op == OP_JMP || (op == OP_JLT && r_sr[3]) ||
                                    (op == OP_JEQ && r_sr[2]) || (op == OP_JGT && r_sr[1]));
    assign cmp_lt = ($signed(dv) < $signed(src));
    assign cmp_eq = (dv == src);

    always_comb begin
        sum = 17'd0;
        unique case (op)
            OP_ADD:  sum = {1'b0, dv} + {1'b0, src};
            OP_ADDC: sum = {1'b0, dv} + {1'b0, src} + {16'd0, r_sr[0]};
            OP_SUB:  sum = {1'b0, dv} - {1'b0, src};
            OP_SUBC: sum = {1'b0, dv} - {1'b0, src} - {16'd0, r_sr[0]};
            default: sum = 17'd0;
        endcase
    end

    // memory address/data muxing
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_loc[MEM_AW-1:0];
        mem_wd = r_val;
        mem_ra = r_loc[MEM_AW-1:0];
        unique case (i_cmd.op)
            C_DIRECT: mem_we = (r_mode == MODE_WMEM);
            C_PRECHECK: mem_ra = r_ip[MEM_AW-1:0];
            C_EXEC: begin
                mem_ra = MEM_AW'(addr + r_base);
                if (op == OP_STORE && !addr_oob) begin
                    mem_we = 1'b1;
                    mem_wa = MEM_AW'(addr + r_base);
                    mem_wd = dv;
                end
            end
            C_PUSH: begin
                mem_we = 1'b1;
                mem_wa = sp_dec[MEM_AW-1:0];
                unique case (r_cnt)
                    3'd0: mem_wd = {7'd0, r_ip};
                    3'd1: mem_wd = r_regs[0];
                    3'd2: mem_wd = r_regs[1];
                    3'd3: mem_wd = r_regs[2];
                    3'd4: mem_wd = r_regs[3];
                    default: mem_wd = r_sr;
                endcase
            end
            C_POPRD: mem_ra = r_sp[MEM_AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    assign o_status.stop    = r_stop;
    assign o_status.is_load = (op == OP_LOAD) && !imm;
    assign o_status.is_call = (op == OP_CALL);
    assign o_status.is_ret  = (op == OP_RET);
    assign o_status.last    = (r_cnt == 3'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) r_regs[j] <= 16'd0;
            r_sr <= 16'd0; r_ip <= 9'd0; r_sp <= 9'd256;
            r_clk <= 32'd0; r_dl <= 32'd0; r_stopped <= 1'b1;
            r_base <= 8'd0; r_size <= 9'd0; r_slen <= 16'd15;
            r_stop <= 1'b0; r_cnt <= 3'd0; r_ev <= EV_NONE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE:  r_base <= i_cfg_data[7:0];
                    CFG_SIZE:  r_size <= i_cfg_data[8:0];
                    CFG_SLICE: r_slen <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                C_NONE: begin
                    r_mode <= i_mode; r_loc <= i_location; r_val <= i_value;
                    r_stop <= 1'b0; r_ev <= EV_NONE; r_cnt <= 3'd0;
                    r_rword <= 16'd0;
                end
                C_DIRECT: begin
                    unique case (r_mode)
                        MODE_WCTX: begin
                            unique case (r_loc)
                                8'd0: r_regs[0] <= r_val;
                                8'd1: r_regs[1] <= r_val;
                                8'd2: r_regs[2] <= r_val;
                                8'd3: r_regs[3] <= r_val;
                                8'd4: r_sr <= r_val;
                                8'd5: r_sp <= r_val[8:0];
                                8'd6: r_ip <= r_val[8:0];
                                default: ;
                            endcase
                        end
                        MODE_SLICE: begin
                            r_dl <= r_clk + {16'd0, r_slen};
                            r_stopped <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                C_PRECHECK, C_POSTCHECK: begin
                    if (r_stop || (i_cmd.op == C_PRECHECK && r_stopped)) begin
                        r_stop <= 1'b1;
                    end else if (ip_oob) begin
                        r_sr <= {8'd0, 3'd2, r_sr[4:0]};
                        r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_OOB;
                    end else if (slice_over) begin
                        r_sr <= {11'd0, r_sr[4:0]};
                        r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_SLICE;
                    end
                end
                C_FETCH: begin
                    if (r_mode == MODE_RMEM) r_rword <= r_rdata;
                end
                C_DECODE: r_ir <= r_rdata;
                C_EXEC: begin
                    r_ip <= jmp_take ? jt : r_ip + 9'd1;
                    r_clk <= r_clk + (mem_cost ? 32'd4 : 32'd1);
                    if (exec_oob) begin
                        r_sr <= {8'd0, 3'd2, r_sr[4:0]};
                        r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_OOB;
                    end else begin
                        unique case (op)
                            OP_LOAD: begin
                                if (imm) r_regs[rd] <= k;
                            end
                            OP_ADD, OP_ADDC, OP_SUB, OP_SUBC: begin
                                r_regs[rd] <= sum[15:0];
                                r_sr[0] <= sum[16];
                                if (op == OP_ADD || op == OP_ADDC)
                                    r_sr[4] <= ~(dv[15] ^ src[15]) & (dv[15] ^ sum[15]);
                                else
                                    r_sr[4] <= (dv[15] ^ src[15]) & (dv[15] ^ sum[15]);
                            end
                            OP_AND: r_regs[rd] <= dv & (imm ? {8'd0, addr} : src);
                            OP_XOR: r_regs[rd] <= dv ^ src;
                            OP_COMPL: r_regs[rd] <= ~dv;
                            OP_SHL: begin r_sr[0] <= dv[15]; r_regs[rd] <= {dv[14:0], 1'b0}; end
                            OP_SHLA: begin
                                r_sr[0] <= dv[15]; r_regs[rd] <= {dv[15], dv[13:0], 1'b0};
                            end
                            OP_SHR: begin r_sr[0] <= dv[0]; r_regs[rd] <= {1'b0, dv[15:1]}; end
                            OP_SHRA: begin r_sr[0] <= dv[0]; r_regs[rd] <= {dv[15], dv[15:1]}; end
                            OP_CMP: r_sr <= {11'd0, r_sr[4], cmp_lt, !cmp_lt && cmp_eq,
                                             !cmp_lt && !cmp_eq, r_sr[0]};
                            OP_GETS: r_regs[rd] <= r_sr;
                            OP_PUTS: r_sr <= dv;
                            OP_STORE, OP_JMP, OP_JLT, OP_JEQ, OP_JGT, OP_CALL, OP_RET,
                            OP_NOOP: ;
                            OP_TRD: begin
                                r_sr <= {6'd0, rd, 3'd6, r_sr[4:0]};
                                r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_READ;
                            end
                            OP_TWR: begin
                                r_sr <= {6'd0, rd, 3'd7, r_sr[4:0]};
                                r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_WRITE;
                            end
                            OP_HALT: begin
                                r_sr <= {8'd0, 3'd1, r_sr[4:0]};
                                r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_HALT;
                            end
                            default: begin
                                r_sr <= {8'd0, 3'd5, r_sr[4:0]};
                                r_stopped <= 1'b1; r_stop <= 1'b1; r_ev <= EV_BADOP;
                            end
                        endcase
                    end
                end
                C_LOADWB: begin
                    if (!r_stop) r_regs[rd] <= r_rdata;
                end
                C_PUSH: begin
                    r_sp <= sp_dec;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) r_ip <= jt;
                end
                C_POPRD: r_sp <= r_sp + 9'd1;
                C_POPWB: begin
                    r_cnt <= r_cnt + 3'd1;
                    unique case (r_cnt)
                        3'd0: r_sr <= r_rdata;
                        3'd1: r_regs[3] <= r_rdata;
                        3'd2: r_regs[2] <= r_rdata;
                        3'd3: r_regs[1] <= r_rdata;
                        3'd4: r_regs[0] <= r_rdata;
                        default: r_ip <= r_rdata[8:0];
                    endcase
                end
            endcase
        end
    end

    assign o_read_word       = r_rword;
    assign o_status_word     = r_sr;
    assign o_program_counter = r_ip;
    assign o_stack_top       = r_sp;
    assign o_elapsed_clock   = r_clk;
    assign o_stop_event      = r_ev;
endmodule

// ===== sv/sbacs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbacs_ctrl
// Sequencer of the CPU step block: handshakes and datapath commands.
// ----------------------------------------------------------------------------
module sbacs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  logic [2:0]          i_mode,
    output sbacs_pkg::t_cmd     o_cmd,
    input  sbacs_pkg::t_status  i_status
);
    import sbacs_pkg::*;

    t_state r_state, n_state;
    logic   r_exec, n_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_exec  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exec  <= n_exec;
        end
    end

    always_comb begin
        n_state = r_state;
        n_exec  = r_exec;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_state = S_ACCESS;
                n_exec  = (i_mode == MODE_EXEC);
            end
            S_ACCESS: n_state = r_exec ? S_FETCH : S_MEMWAIT;
            S_MEMWAIT: n_state = S_DONE;
            S_FETCH: n_state = i_status.stop ? S_DONE : S_DECODE;
            S_DECODE: n_state = S_EXEC;
            S_EXEC: begin
                if (i_status.stop) n_state = S_DONE;
                else if (i_status.is_load) n_state = S_POPWAIT;
                else if (i_status.is_call) n_state = S_PUSH;
                else if (i_status.is_ret) n_state = S_POP;
                else n_state = S_CHECK;
            end
            S_PUSH: if (i_status.last) n_state = S_CHECK;
            S_POP: n_state = S_POPWAIT;
            S_POPWAIT: begin
                if (i_status.is_ret && !i_status.last) n_state = S_POP;
                else n_state = S_CHECK;
            end
            S_CHECK: n_state = S_DONE;
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = C_NONE;
        o_ready  = (r_state == S_IDLE);
        o_valid  = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE:    o_cmd.op = C_NONE;
            S_ACCESS:  o_cmd.op = r_exec ? C_PRECHECK : C_DIRECT;
            S_MEMWAIT: o_cmd.op = C_FETCH;
            S_FETCH:   o_cmd.op = C_DECODE;
            S_DECODE:  o_cmd.op = C_FETCH;
            S_EXEC:    o_cmd.op = C_EXEC;
            S_PUSH:    o_cmd.op = C_PUSH;
            S_POP:     o_cmd.op = C_POPRD;
            S_POPWAIT: o_cmd.op = (i_status.is_ret) ? C_POPWB : C_LOADWB;
            S_CHECK:   o_cmd.op = C_POSTCHECK;
            default:   o_cmd.op = C_FETCH;
        endcase
    end
endmodule

// ===== sv/sixteen_bit_accumulator_cpu_step.sv =====
// ----------------------------------------------------------------------------
// sixteen_bit_accumulator_cpu_step
// Top level of a small 16-bit CPU that moves one step per input beat.
// ----------------------------------------------------------------------------
// One input beat gives one result beat. An executed instruction goes through
// fetch through the single memory read port, decode, execute and bound check;
// a load adds a write-back of the read word, and a call or a return moves each
// of the six stack words one at a time through the one memory port. A step
// refused before fetch ends after the first bound check.
// Configuration writes land at once.
module sixteen_bit_accumulator_cpu_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_location,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_read_word,
    output logic [15:0] o_status_word,
    output logic [8:0]  o_program_counter,
    output logic [8:0]  o_stack_top,
    output logic [31:0] o_elapsed_clock,
    output logic [2:0]  o_stop_event
);
    import sbacs_pkg::*;

    t_cmd    cmd;
    t_status status;

    sbacs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .i_mode,
        .o_cmd(cmd), .i_status(status)
    );

    sbacs_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_mode, .i_location, .i_value,
        .o_read_word, .o_status_word, .o_program_counter, .o_stack_top,
        .o_elapsed_clock, .o_stop_event
    );
endmodule

// ===== sv/sbacs_checker.sv =====
// ----------------------------------------------------------------------------
// sbacs_checker
// Port-level checks of the CPU step block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sbacs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_read_word,
    input logic [8:0]  o_stack_top
);
    `CHK_IMPL(a_one_side, i_clk, i_rst_n, 1'b1, !(o_ready && o_valid))
    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `CHK_IMPL(a_hold_result, i_clk, i_rst_n, o_valid && !i_ready && $past(o_valid), $stable(o_read_word))
    `CHK_IMPL(a_hold_sp, i_clk, i_rst_n, o_valid && !i_ready && $past(o_valid), $stable(o_stack_top))
    `CHK_NEXT(a_done_frees, i_clk, i_rst_n, o_valid && i_ready, o_ready)
endmodule

bind sixteen_bit_accumulator_cpu_step sbacs_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_read_word, .o_stack_top
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 16-bit CPU step block: a built-in predictor
// follows every accepted beat; results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import sbacs_pkg::*;

    typedef struct {
        logic [15:0] rd_word;
        logic [15:0] status;
        logic [8:0]  pc;
        logic [8:0]  sp;
        logic [31:0] clock;
        logic [2:0]  ev;
    } step_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_mode = '0;
    logic [7:0]  i_location = '0;
    logic [15:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_read_word;
    logic [15:0] o_status_word;
    logic [8:0]  o_program_counter;
    logic [8:0]  o_stack_top;
    logic [31:0] o_elapsed_clock;
    logic [2:0]  o_stop_event;

    sixteen_bit_accumulator_cpu_step i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] p_mem [256];
    logic [15:0] p_regs [4];
    logic [15:0] p_sr;
    logic [8:0]  p_ip;
    logic [8:0]  p_sp;
    logic [31:0] p_clk;
    logic [31:0] p_deadline;
    logic        p_stopped;
    logic [7:0]  p_base;
    logic [8:0]  p_size;
    logic [15:0] p_slice;

    step_result_t pending_results[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int stops_seen = 0;
    logic quiet = 1'b0;
    int hold_seq = 0;
    int seen_hold = 0;
    int hold_left = 0;
    int stall_left = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("ERROR %0t: %s got %h exp %h", $time, what, got, exp);
        errors++;
    endtask

    function automatic logic [2:0] halt_with(logic [15:0] code, logic [15:0] extra,
                                             logic [2:0] ev);
        p_sr = (p_sr & 16'h001f) | code | extra;
        p_stopped = 1'b1;
        return ev;
    endfunction

    function automatic logic [2:0] check_bounds();
        logic [31:0] d;
        if ({1'b0, p_ip} >= {2'b0, p_base} + {1'b0, p_size})
            return halt_with(16'h0040, 16'h0, EV_OOB);
        d = p_deadline - p_clk;
        if (d == 0 || d[31])
            return halt_with(16'h0, 16'h0, EV_SLICE);
        return EV_NONE;
    endfunction

    function automatic logic [15:0] alu_arith(logic [15:0] a, logic [15:0] b,
                                              logic cin, logic sub);
        logic [16:0] s;
        logic [15:0] r;
        logic cy, ov;
        if (sub) begin
            r = a - b - cin;
            cy = {1'b0, a} < ({1'b0, b} + cin);
            ov = ((a ^ b) & (a ^ r) & 16'h8000) != 0;
        end else begin
            s = a + b + cin;
            r = s[15:0];
            cy = s[16];
            ov = ((~(a ^ b)) & (a ^ r) & 16'h8000) != 0;
        end
        p_sr[0] = cy;
        p_sr[4] = ov;
        return r;
    endfunction

    function automatic logic [2:0] run_insn();
        logic [15:0] ir, k, src;
        logic [4:0]  op;
        logic [1:0]  rd, rs;
        logic        imm, cin;
        logic [7:0]  addr;
        logic [8:0]  target;
        ir = p_mem[p_ip[7:0]];
        op = ir[15:11];
        rd = ir[10:9];
        imm = ir[8];
        rs = ir[7:6];
        addr = ir[7:0];
        k = {{8{addr[7]}}, addr};
        src = imm ? k : p_regs[rs];
        cin = p_sr[0];
        target = {1'b0, addr} + {1'b0, p_base};
        p_ip = p_ip + 9'd1;
        p_clk = p_clk + 1;
        if ((op <= OP_STORE && !(op == OP_LOAD && imm)) || (op >= OP_JMP && op <= OP_JGT)) begin
            if ({1'b0, addr} >= p_size) return halt_with(16'h0040, 16'h0, EV_OOB);
        end
        case (op)
            OP_LOAD: begin
                if (imm) p_regs[rd] = k;
                else begin
                    p_regs[rd] = p_mem[target[7:0]];
                    p_clk = p_clk + 3;
                end
            end
            OP_STORE: begin
                p_mem[target[7:0]] = p_regs[rd];
                p_clk = p_clk + 3;
            end
            OP_ADD:  p_regs[rd] = alu_arith(p_regs[rd], src, 1'b0, 1'b0);
            OP_ADDC: p_regs[rd] = alu_arith(p_regs[rd], src, cin, 1'b0);
            OP_SUB:  p_regs[rd] = alu_arith(p_regs[rd], src, 1'b0, 1'b1);
            OP_SUBC: p_regs[rd] = alu_arith(p_regs[rd], src, cin, 1'b1);
            OP_AND:  p_regs[rd] = p_regs[rd] & (imm ? {8'h0, addr} : src);
            OP_XOR:  p_regs[rd] = p_regs[rd] ^ src;
            OP_COMPL: p_regs[rd] = ~p_regs[rd];
            OP_SHL, OP_SHLA: begin
                p_sr[0] = p_regs[rd][15];
                if (op == OP_SHL) p_regs[rd] = p_regs[rd] << 1;
                else p_regs[rd] = {p_regs[rd][15], p_regs[rd][13:0], 1'b0};
            end
            OP_SHR, OP_SHRA: begin
                p_sr[0] = p_regs[rd][0];
                if (op == OP_SHR) p_regs[rd] = p_regs[rd] >> 1;
                else p_regs[rd] = {p_regs[rd][15], p_regs[rd][15:1]};
            end
            OP_CMP: begin
                p_sr = p_sr & 16'h0011;
                if ($signed(p_regs[rd]) < $signed(src)) p_sr[3] = 1'b1;
                else if (p_regs[rd] == src) p_sr[2] = 1'b1;
                else p_sr[1] = 1'b1;
            end
            OP_GETS: p_regs[rd] = p_sr;
            OP_PUTS: p_sr = p_regs[rd];
            OP_JMP: p_ip = target;
            OP_JLT: if (p_sr[3]) p_ip = target;
            OP_JEQ: if (p_sr[2]) p_ip = target;
            OP_JGT: if (p_sr[1]) p_ip = target;
            OP_CALL: begin
                p_sp = p_sp - 9'd1;
                p_mem[p_sp[7:0]] = {7'h0, p_ip};
                for (int n = 0; n < 4; n++) begin
                    p_sp = p_sp - 9'd1;
                    p_mem[p_sp[7:0]] = p_regs[n];
                end
                p_sp = p_sp - 9'd1;
                p_mem[p_sp[7:0]] = p_sr;
                p_ip = target;
                p_clk = p_clk + 3;
            end
            OP_RET: begin
                p_sr = p_mem[p_sp[7:0]];
                p_sp = p_sp + 9'd1;
                for (int n = 3; n >= 0; n--) begin
                    p_regs[n] = p_mem[p_sp[7:0]];
                    p_sp = p_sp + 9'd1;
                end
                p_ip = p_mem[p_sp[7:0]][8:0];
                p_sp = p_sp + 9'd1;
                p_clk = p_clk + 3;
            end
            OP_TRD:  return halt_with(16'h00c0, {6'h0, rd, 8'h0}, EV_READ);
            OP_TWR:  return halt_with(16'h00e0, {6'h0, rd, 8'h0}, EV_WRITE);
            OP_HALT: return halt_with(16'h0020, 16'h0, EV_HALT);
            OP_NOOP: ;
            default: return halt_with(16'h00a0, 16'h0, EV_BADOP);
        endcase
        return check_bounds();
    endfunction

    task automatic predict_step(input logic [2:0] m, input logic [7:0] l, input logic [15:0] v);
        step_result_t r;
        r.rd_word = '0;
        r.ev = EV_NONE;
        case (m)
            MODE_WMEM: p_mem[l] = v;
            MODE_RMEM: r.rd_word = p_mem[l];
            MODE_WCTX: begin
                if (l < 4) p_regs[l[1:0]] = v;
                else if (l == 4) p_sr = v;
                else if (l == 5) p_sp = v[8:0];
                else if (l == 6) p_ip = v[8:0];
            end
            MODE_SLICE: begin
                p_deadline = p_clk + p_slice;
                p_stopped = 1'b0;
            end
            MODE_EXEC: begin
                if (!p_stopped) begin
                    r.ev = check_bounds();
                    if (r.ev == EV_NONE) r.ev = run_insn();
                end
            end
            default: ;
        endcase
        r.status = p_sr;
        r.pc = p_ip;
        r.sp = p_sp;
        r.clock = p_clk;
        pending_results.push_back(r);
    endtask

    task automatic send_beat(input logic [2:0] m, input logic [7:0] l, input logic [15:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_location <= l;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_step(m, l, v);
        beats_in++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_BASE:  p_base = data[7:0];
            CFG_SIZE:  p_size = data[8:0];
            CFG_SLICE: p_slice = data;
            default: ;
        endcase
    endtask

    task automatic set_partition(input logic [7:0] b, input logic [8:0] s, input logic [15:0] sl);
        drain();
        write_cfg(CFG_BASE, {8'h0, b});
        write_cfg(CFG_SIZE, {7'h0, s});
        write_cfg(CFG_SLICE, sl);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic logic [15:0] pick_insn();
        logic [4:0] op;
        logic [7:0] addr;
        op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31)) :
                                           5'($urandom_range(0, 25));
        if (p_size != 0 && $urandom_range(0, 4) != 0)
            addr = 8'($urandom_range(0, (p_size > 256 ? 255 : p_size - 1)));
        else
            addr = 8'($urandom_range(0, 255));
        return {op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), addr};
    endfunction

    // memory fill, reads, context writes, ignored modes, an exec while stopped
    task automatic test_access();
        for (int a = 0; a < 256; a++) send_beat(MODE_WMEM, a[7:0], pick_word());
        send_beat(MODE_RMEM, 8'h00, 16'h0);
        send_beat(MODE_RMEM, 8'hff, 16'hffff);
        for (int c = 0; c < 8; c++) send_beat(MODE_WCTX, c[7:0], pick_word());
        for (int m = 5; m < 8; m++) send_beat(m[2:0], 8'hff, 16'hffff);
        send_beat(MODE_EXEC, 8'h00, 16'h0);
    endtask

    // one instruction of every opcode from a fresh slice
    task automatic test_each_opcode();
        logic [15:0] w;
        set_partition(8'h00, 9'd256, 16'hffff);
        for (int op = 0; op < 32; op++) begin
            w = pick_insn();
            send_beat(MODE_WMEM, 8'd10, {op[4:0], w[10:0]});
            send_beat(MODE_WCTX, 8'd6, 16'd10);
            send_beat(MODE_WCTX, 8'd4, pick_word());
            send_beat(MODE_SLICE, 8'h00, 16'h0);
            send_beat(MODE_EXEC, 8'h00, 16'h0);
        end
    endtask

    task automatic run_program(input int n_insns, input int n_exec);
        for (int k = 0; k < n_insns; k++) send_beat(MODE_WMEM, p_base + 8'(k), pick_insn());
        for (int c = 0; c < 4; c++)
            if ($urandom_range(0, 1)) send_beat(MODE_WCTX, c[7:0], pick_word());
        if ($urandom_range(0, 2) == 0) send_beat(MODE_WCTX, 8'd4, pick_word());
        if ($urandom_range(0, 3) == 0) send_beat(MODE_WCTX, 8'd5, pick_word());
        send_beat(MODE_WCTX, 8'd6,
                  ($urandom_range(0, 9) == 0) ? pick_word() : {8'h0, p_base});
        send_beat(MODE_SLICE, 8'h00, 16'h0);
        for (int e = 0; e < n_exec; e++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pick_word());
            else
                send_beat(MODE_EXEC, 8'h00, 16'h0);
        end
    endtask

    // out of bound and slice expiry with tight partitions
    task automatic test_bounds();
        set_partition(8'h00, 9'd0, 16'd1);
        run_program(2, 3);
        set_partition(8'hff, 9'd1, 16'd3);
        run_program(1, 4);
        set_partition(8'd200, 9'd56, 16'd15);
        run_program(6, 12);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        set_partition(8'h00, 9'd256, 16'hffff);
        hold_seq <= hold_seq + 1;
        quiet <= 1'b1;
        run_program(8, 30);
        quiet <= 1'b0;
    endtask

    task automatic test_random_programs();
        int run_lens;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_partition(8'h00, 9'd256, 16'hffff);
                1: set_partition(8'h10, 9'd64, 16'd40);
                2: set_partition(8'hc0, 9'd64, 16'd1);
                3: set_partition(8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)),
                                 16'($urandom_range(1, 65535)));
                4: set_partition(8'hff, 9'd256, 16'd200);
                default: set_partition(8'h00, 9'd32, 16'd25);
            endcase
            quiet <= (ph == 4);
            run_lens = 0;
            while (run_lens < 60) begin
                run_program($urandom_range(3, 10), $urandom_range(5, 20));
                run_lens = run_lens + 20;
            end
        end
        quiet <= 1'b0;
    endtask

    // long hold-off of the result side
    always @(posedge i_clk) begin
        if (hold_seq != seen_hold) begin
            seen_hold <= hold_seq;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result side: random stalls, checks in order
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                report("unexpected result beat", 32'h0, 32'h0);
            end else begin
                step_result_t e;
                e = pending_results.pop_front();
                if (o_read_word !== e.rd_word)
                    report("read_word", 32'(o_read_word), 32'(e.rd_word));
                if (o_status_word !== e.status)
                    report("status_word", 32'(o_status_word), 32'(e.status));
                if (o_program_counter !== e.pc)
                    report("program_counter", 32'(o_program_counter), 32'(e.pc));
                if (o_stack_top !== e.sp)
                    report("stack_top", 32'(o_stack_top), 32'(e.sp));
                if (o_elapsed_clock !== e.clock)
                    report("elapsed_clock", o_elapsed_clock, e.clock);
                if (o_stop_event !== e.ev)
                    report("stop_event", 32'(o_stop_event), 32'(e.ev));
                if (e.ev != EV_NONE) stops_seen++;
            end
            stall_left = quiet ? 0 : $urandom_range(0, 11);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_ready <= i_rst_n && stall_left == 0 && hold_left == 0;
    end

    initial begin
        for (int a = 0; a < 256; a++) p_mem[a] = '0;
        for (int r = 0; r < 4; r++) p_regs[r] = '0;
        p_sr = '0;
        p_ip = '0;
        p_sp = 9'd256;
        p_clk = '0;
        p_deadline = '0;
        p_stopped = 1'b1;
        p_base = '0;
        p_size = '0;
        p_slice = 16'd15;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_access();
        test_each_opcode();
        test_bounds();
        test_backpressure();
        test_random_programs();
        drain();
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0)
            report("results left over", pending_results.size(), 32'h0);
        $display("Sent %0d beats, checked %0d results, %0d of them stop events.",
                 beats_in, beats_out, stops_seen);
        $display("Covered all opcodes, context writes, bound and slice stops, long back-pressure.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TIMEOUT at %0t", $time);
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/sbacs_pkg.sv
sv/sbacs_datapath.sv
sv/sbacs_ctrl.sv
sv/sixteen_bit_accumulator_cpu_step.sv
sv/sbacs_checker.sv
tb/tb.sv
